// ----- src/daylight_dimming_level_control_defines.svh -----
// ---------------------------------------------------------------------------
// Daylight dimming level control: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DAYLIGHT_DIMMING_LEVEL_CONTROL_DEFINES_SVH
`define DAYLIGHT_DIMMING_LEVEL_CONTROL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ddlc_pkg.sv -----
// ---------------------------------------------------------------------------
// Daylight dimming level control: package
// Widths, codes and the types shared between the modules of the block.
// ---------------------------------------------------------------------------
package ddlc_pkg;

  localparam int unsigned LUX_W     = 16;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned BOARD_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 23;
  localparam int unsigned CLAMP_W   = 8;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned ITER_W    = 5;

  localparam logic [ITER_W-1:0]  ITER_LAST   = ITER_W'(PROD_W - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_MIN_ON = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] LEVEL_OFF   = '0;

  localparam logic [LUX_W-1:0] FULL_SCALE_RESET = LUX_W'(600);

  typedef enum logic [BOARD_W-1:0] {
    BOARD_INTEGRATED = 2'd0,
    BOARD_TRIAC      = 2'd1,
    BOARD_OTHER      = 2'd2,
    BOARD_SPARE      = 2'd3
  } ddlc_board_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LUX     = 3'd0,
    CFG_FULL_SCALE_LUX = 3'd1,
    CFG_AREA_MODE      = 3'd2,
    CFG_IN_AREA        = 3'd3,
    CFG_OUTPUT_PATH    = 3'd4,
    CFG_BOARD_KIND     = 3'd5,
    CFG_OCC_GATING     = 3'd6,
    CFG_EMERG_HOLD     = 3'd7
  } ddlc_cfg_idx_e;

  typedef struct packed {
    logic [LUX_W-1:0]   target_lux;
    logic [LUX_W-1:0]   full_scale_lux;
    logic               area_mode;
    logic               in_area;
    logic               output_path;
    logic [BOARD_W-1:0] board_kind;
    logic               occupancy_gating;
    logic               emergency_hold;
  } ddlc_cfg_t;

  typedef struct packed {
    logic opcode;
    logic occupied;
    logic override_flag;
    logic is_request;
  } ddlc_evt_t;

  typedef struct packed {
    logic               level_valid;
    logic [LEVEL_W-1:0] level;
    logic               switch_valid;
    logic               switch_on;
    logic               off_timer_start;
  } ddlc_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ddlc_div_stat_t;

endpackage

// ----- src/ddlc_intf.sv -----
// ---------------------------------------------------------------------------
// Daylight dimming level control: channel interfaces
// Valid/ready channels for sensor events and for issued control results.
// ---------------------------------------------------------------------------
interface ddlc_evt_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic                        occupied;
  logic [ddlc_pkg::LUX_W-1:0]  lux;
  logic                        override;
  logic                        is_request;

  modport source (output valid, output opcode, output occupied, output lux,
                  output override, output is_request, input ready);
  modport sink   (input valid, input opcode, input occupied, input lux,
                  input override, input is_request, output ready);
endinterface

interface ddlc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          level_valid;
  logic [ddlc_pkg::LEVEL_W-1:0]  level;
  logic                          switch_valid;
  logic                          switch_on;
  logic                          off_timer_start;

  modport source (output valid, output level_valid, output level, output switch_valid,
                  output switch_on, output off_timer_start, input ready);
  modport sink   (input valid, input level_valid, input level, input switch_valid,
                  input switch_on, input off_timer_start, output ready);
endinterface

// ----- src/ddlc_serial_div.sv -----
// ---------------------------------------------------------------------------
// Daylight dimming level control: bit-serial divider
// Scales the lux deficit by 100, then divides it by the full-scale value one
// quotient bit per cycle with a restoring shift-subtract step.
// ---------------------------------------------------------------------------
`include "daylight_dimming_level_control_defines.svh"

module ddlc_serial_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ddlc_pkg::LUX_W-1:0]          mag_i,
  input  logic [ddlc_pkg::LUX_W-1:0]          den_i,
  output ddlc_pkg::ddlc_div_stat_t            stat_o,
  output logic [ddlc_pkg::PROD_W-1:0]         quot_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_ITER,
    D_DONE
  } div_state_e;

  div_state_e                       state_q;
  logic [ddlc_pkg::ITER_W-1:0]      cnt_q;
  logic [ddlc_pkg::LUX_W-1:0]       mag_q;
  logic [ddlc_pkg::LUX_W-1:0]       den_q;
  logic [ddlc_pkg::LUX_W-1:0]       rem_q;
  logic [ddlc_pkg::PROD_W-1:0]      dvd_q;
  logic [ddlc_pkg::PROD_W-1:0]      prod;
  logic [ddlc_pkg::LUX_W:0]         trial;
  logic                             qbit;
  logic [ddlc_pkg::LUX_W:0]         trial_sub;

  assign prod = (ddlc_pkg::PROD_W'(mag_q) << 6) + (ddlc_pkg::PROD_W'(mag_q) << 5)
              + (ddlc_pkg::PROD_W'(mag_q) << 2);
  assign trial     = {rem_q, dvd_q[ddlc_pkg::PROD_W-1]};
  assign qbit      = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= D_PREP;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        D_PREP: begin
          state_q <= D_ITER;
        end
        D_ITER: begin
          if (cnt_q == ddlc_pkg::ITER_LAST) begin
            state_q <= D_DONE;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        D_IDLE, D_DONE: begin
          state_q <= state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      den_q <= (den_i == '0) ? ddlc_pkg::LUX_W'(1) : den_i;
    end else if (state_q == D_PREP) begin
      dvd_q <= prod;
      rem_q <= '0;
    end else if (state_q == D_ITER) begin
      rem_q <= qbit ? trial_sub[ddlc_pkg::LUX_W-1:0] : trial[ddlc_pkg::LUX_W-1:0];
      dvd_q <= {dvd_q[ddlc_pkg::PROD_W-2:0], qbit};
    end
  end

  assign stat_o.busy = (state_q == D_PREP) || (state_q == D_ITER);
  assign stat_o.done = (state_q == D_DONE);
  assign quot_o      = dvd_q;

  `DDLC_ASSERT_NEXT(a_start_clears_done, start_i, !stat_o.done && stat_o.busy, "divider did not restart")
  `DDLC_ASSERT_NEXT(a_done_holds, stat_o.done && !start_i, stat_o.done && $stable(quot_o), "divider result not held")

endmodule

// ----- src/ddlc_level_map.sv -----
// ---------------------------------------------------------------------------
// Daylight dimming level control: level mapping and command decision
// Turns the signed quotient into a clamped dim level and derives the issued
// level, power-switch command, off-timer start and the stored level.
// ---------------------------------------------------------------------------
module ddlc_level_map (
  input  ddlc_pkg::ddlc_cfg_t              cfg_i,
  input  ddlc_pkg::ddlc_evt_t              evt_i,
  input  logic [ddlc_pkg::PROD_W-1:0]      quot_i,
  input  logic                             neg_i,
  input  logic [ddlc_pkg::LEVEL_W-1:0]     prev_i,
  output ddlc_pkg::ddlc_res_t              res_o,
  output logic                             prev_we_o,
  output logic [ddlc_pkg::LEVEL_W-1:0]     prev_o
);

  logic [ddlc_pkg::CLAMP_W-1:0]       qc;
  logic signed [ddlc_pkg::SUM_W-1:0]  sum;
  logic [ddlc_pkg::LEVEL_W-1:0]       lvl;
  logic [ddlc_pkg::LEVEL_W-1:0]       gated;
  logic                               active;
  logic                               grouped;
  logic                               lvl_on;
  logic                               is_integ;
  logic                               is_triac;

  assign qc = (|quot_i[ddlc_pkg::PROD_W-1:ddlc_pkg::CLAMP_W]) ? '1
                                                               : quot_i[ddlc_pkg::CLAMP_W-1:0];
  assign sum = neg_i ? $signed(ddlc_pkg::SUM_W'(prev_i)) - $signed(ddlc_pkg::SUM_W'(qc))
                     : $signed(ddlc_pkg::SUM_W'(prev_i)) + $signed(ddlc_pkg::SUM_W'(qc));

  always_comb begin
    if (sum <= $signed(ddlc_pkg::SUM_W'(ddlc_pkg::LEVEL_MIN_ON))) begin
      lvl = ddlc_pkg::LEVEL_OFF;
    end else if (sum > $signed(ddlc_pkg::SUM_W'(ddlc_pkg::LEVEL_FULL))) begin
      lvl = ddlc_pkg::LEVEL_FULL;
    end else begin
      lvl = sum[ddlc_pkg::LEVEL_W-1:0];
    end
  end

  assign active   = !evt_i.is_request && !evt_i.override_flag;
  assign grouped  = cfg_i.area_mode && cfg_i.in_area && evt_i.occupied;
  assign lvl_on   = (lvl != ddlc_pkg::LEVEL_OFF);
  assign gated    = evt_i.occupied ? lvl : ddlc_pkg::LEVEL_OFF;
  assign is_integ = (cfg_i.board_kind == ddlc_pkg::BOARD_INTEGRATED);
  assign is_triac = (cfg_i.board_kind == ddlc_pkg::BOARD_TRIAC);

  always_comb begin
    res_o     = '0;
    prev_we_o = 1'b0;
    prev_o    = lvl;
    if (!evt_i.opcode && active) begin
      if (!cfg_i.output_path) begin
        if (is_integ) begin
          if (cfg_i.area_mode) begin
            if (grouped) begin
              res_o.switch_valid = 1'b1;
              res_o.switch_on    = 1'b1;
            end
          end else begin
            if (evt_i.occupied && lvl_on) begin
              res_o.switch_valid = 1'b1;
              res_o.switch_on    = 1'b1;
            end
            res_o.off_timer_start = !cfg_i.emergency_hold && !evt_i.occupied;
          end
        end
        if (cfg_i.area_mode) begin
          if (grouped) begin
            res_o.level_valid = 1'b1;
            res_o.level       = ddlc_pkg::LEVEL_FULL;
          end
        end else begin
          res_o.level_valid = 1'b1;
          res_o.level       = gated;
          prev_we_o         = 1'b1;
          prev_o            = gated;
        end
      end else begin
        if (cfg_i.area_mode) begin
          if (grouped) begin
            res_o.level_valid = 1'b1;
            res_o.level       = ddlc_pkg::LEVEL_FULL;
            prev_we_o         = 1'b1;
          end
        end else begin
          res_o.level_valid = 1'b1;
          res_o.level       = gated;
          prev_we_o         = 1'b1;
          prev_o            = gated;
        end
      end
      if (is_triac) begin
        res_o.switch_valid = 1'b1;
        res_o.switch_on    = evt_i.occupied && lvl_on;
      end
    end else if (evt_i.opcode && active && cfg_i.occupancy_gating && evt_i.occupied) begin
      if (is_triac) begin
        res_o.switch_valid = 1'b1;
        res_o.switch_on    = lvl_on;
      end
      if (!cfg_i.area_mode) begin
        res_o.level_valid = 1'b1;
        res_o.level       = lvl;
        prev_we_o         = 1'b1;
        if (!cfg_i.output_path && is_integ) begin
          res_o.switch_valid = 1'b1;
          res_o.switch_on    = lvl_on;
        end
      end
    end
  end

endmodule

// ----- src/daylight_dimming_level_control.sv -----
// An accepted event runs through the bit-serial divider: a set-up step for the
// scaling by 100, then one quotient bit per cycle for 23 bits. Its result is then
// registered once the output register is free; no new event is taken until then.
// A waiting result sits in the output register and does not block the next event.
// Reset (rst_ni low, asynchronous): control and configuration registers take their
// reset values, the stored level clears to zero and no result is pending.
// ---------------------------------------------------------------------------
// Daylight dimming level control: top level
// Holds configuration and the stored level, sequences the serial divider and
// registers each result transaction for the downstream side.
// ---------------------------------------------------------------------------
`include "daylight_dimming_level_control_defines.svh"

module daylight_dimming_level_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ddlc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddlc_pkg::LUX_W-1:0]          cfg_data_i,
  ddlc_evt_if.sink                            evt_i,
  ddlc_res_if.source                          res_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } ctl_state_e;

  ctl_state_e                        state_q;
  ddlc_pkg::ddlc_cfg_t               cfg_q;
  ddlc_pkg::ddlc_evt_t               evt_q;
  logic                              neg_q;
  logic [ddlc_pkg::LEVEL_W-1:0]      prev_q;
  logic                              out_valid_q;
  ddlc_pkg::ddlc_res_t               out_q;

  logic                              accept;
  logic                              commit;
  logic [ddlc_pkg::LUX_W-1:0]        mag;
  logic                              lux_above;
  ddlc_pkg::ddlc_div_stat_t          div_stat;
  logic [ddlc_pkg::PROD_W-1:0]       quot;
  ddlc_pkg::ddlc_res_t               res_d;
  logic                              prev_we;
  logic [ddlc_pkg::LEVEL_W-1:0]      prev_d;

  assign evt_i.ready = (state_q == S_IDLE);
  assign accept      = evt_i.valid && evt_i.ready;
  assign commit      = (state_q == S_RUN) && div_stat.done && (!out_valid_q || res_o.ready);

  assign lux_above = (evt_i.lux > cfg_q.target_lux);
  assign mag       = lux_above ? (evt_i.lux - cfg_q.target_lux) : (cfg_q.target_lux - evt_i.lux);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_lux       <= '0;
      cfg_q.full_scale_lux   <= ddlc_pkg::FULL_SCALE_RESET;
      cfg_q.area_mode        <= 1'b0;
      cfg_q.in_area          <= 1'b0;
      cfg_q.output_path      <= 1'b0;
      cfg_q.board_kind       <= ddlc_pkg::BOARD_INTEGRATED;
      cfg_q.occupancy_gating <= 1'b1;
      cfg_q.emergency_hold   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ddlc_pkg::ddlc_cfg_idx_e'(cfg_idx_i))
        ddlc_pkg::CFG_TARGET_LUX:     cfg_q.target_lux       <= cfg_data_i;
        ddlc_pkg::CFG_FULL_SCALE_LUX: cfg_q.full_scale_lux   <= cfg_data_i;
        ddlc_pkg::CFG_AREA_MODE:      cfg_q.area_mode        <= cfg_data_i[0];
        ddlc_pkg::CFG_IN_AREA:        cfg_q.in_area          <= cfg_data_i[0];
        ddlc_pkg::CFG_OUTPUT_PATH:    cfg_q.output_path      <= cfg_data_i[0];
        ddlc_pkg::CFG_BOARD_KIND:     cfg_q.board_kind       <= cfg_data_i[ddlc_pkg::BOARD_W-1:0];
        ddlc_pkg::CFG_OCC_GATING:     cfg_q.occupancy_gating <= cfg_data_i[0];
        ddlc_pkg::CFG_EMERG_HOLD:     cfg_q.emergency_hold   <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
        if (prev_we) begin
          prev_q <= prev_d;
        end
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q.opcode        <= evt_i.opcode;
      evt_q.occupied      <= evt_i.occupied;
      evt_q.override_flag <= evt_i.override;
      evt_q.is_request    <= evt_i.is_request;
      neg_q               <= lux_above;
    end
    if (commit) begin
      out_q <= res_d;
    end
  end

  ddlc_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .mag_i   (mag),
    .den_i   (cfg_q.full_scale_lux),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  ddlc_level_map u_map (
    .cfg_i     (cfg_q),
    .evt_i     (evt_q),
    .quot_i    (quot),
    .neg_i     (neg_q),
    .prev_i    (prev_q),
    .res_o     (res_d),
    .prev_we_o (prev_we),
    .prev_o    (prev_d)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.level_valid     = out_q.level_valid;
  assign res_o.level           = out_q.level;
  assign res_o.switch_valid    = out_q.switch_valid;
  assign res_o.switch_on       = out_q.switch_on;
  assign res_o.off_timer_start = out_q.off_timer_start;

  `DDLC_ASSERT_NEXT(a_one_event_in_flight, accept, !evt_i.ready, "second event accepted while busy")
  `DDLC_ASSERT_IMPL(a_commit_slot_free, commit, !out_valid_q || res_o.ready, "result overwritten before transfer")
  `DDLC_ASSERT_IMPL(a_level_range, res_o.valid, (res_o.level == ddlc_pkg::LEVEL_OFF) || ((res_o.level > ddlc_pkg::LEVEL_MIN_ON) && (res_o.level <= ddlc_pkg::LEVEL_FULL)), "issued level out of range")
  `DDLC_ASSERT_IMPL(a_switch_on_needs_valid, res_o.valid && res_o.switch_on, res_o.switch_valid, "switch on without a switch command")

endmodule

// ----- bench/daylight_dimming_level_control_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Daylight dimming level control: testbench
// Runs a short scripted sequence of occupancy and light events over the main
// configurations, then random phases that each load a fresh configuration.
// Every accepted event transaction is predicted locally, and each result
// transaction is checked field by field against the oldest awaited result.
// ---------------------------------------------------------------------------
module daylight_dimming_level_control_tb;
  import ddlc_pkg::*;

  localparam int unsigned RandomItems  = 1200;
  localparam int unsigned Phases       = 12;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned SettleCycles = 40;

  localparam logic OP_OCCUPANCY = 1'b0;
  localparam logic OP_LIGHT     = 1'b1;

  localparam ddlc_res_t NO_ACTION = '0;

  typedef struct packed {
    logic             opcode;
    logic             occupied;
    logic [LUX_W-1:0] lux;
    logic             override_flag;
    logic             is_request;
  } sensor_evt_t;

  typedef struct packed {
    bit               is_write;
    ddlc_cfg_idx_e    reg_idx;
    logic [LUX_W-1:0] reg_val;
    sensor_evt_t      evt;
    bit               known;
    ddlc_res_t        lit;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LUX_W-1:0]     cfg_data;

  ddlc_evt_if evt_if ();
  ddlc_res_if res_if ();

  ddlc_cfg_t          shadow_cfg;
  logic [LEVEL_W-1:0] stored_level;
  ddlc_res_t          awaited_commands[$];
  int unsigned        mismatch_count = 0;
  logic               calm = 1'b0;
  int                 stall_left = 0;

  always #2 clk_i = ~clk_i;

  daylight_dimming_level_control u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  function automatic logic [LEVEL_W-1:0] dim_level(input logic [LUX_W-1:0] lux);
    int deficit;
    int scale;
    int lvl;
    deficit = int'(shadow_cfg.target_lux) - int'(lux);
    scale = (shadow_cfg.full_scale_lux == '0) ? 1 : int'(shadow_cfg.full_scale_lux);
    lvl = (deficit * 100) / scale + int'(stored_level);
    if (lvl <= 10) lvl = 0;
    if (lvl > 100) lvl = 100;
    return LEVEL_W'(lvl);
  endfunction

  function automatic ddlc_res_t control_outcome(input sensor_evt_t e);
    ddlc_res_t          r;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] gated;
    logic               active;
    logic               grouped;
    logic               triac;
    logic               integrated;
    r = NO_ACTION;
    active = !e.is_request && !e.override_flag;
    grouped = shadow_cfg.area_mode && shadow_cfg.in_area && e.occupied;
    triac = (shadow_cfg.board_kind == BOARD_TRIAC);
    integrated = (shadow_cfg.board_kind == BOARD_INTEGRATED);
    lvl = dim_level(e.lux);
    gated = e.occupied ? lvl : LEVEL_OFF;
    if (active && e.opcode == OP_OCCUPANCY) begin
      if (!shadow_cfg.output_path && integrated) begin
        if (shadow_cfg.area_mode) begin
          if (grouped) begin
            r.switch_valid = 1'b1;
            r.switch_on = 1'b1;
          end
        end else begin
          if (e.occupied && lvl != LEVEL_OFF) begin
            r.switch_valid = 1'b1;
            r.switch_on = 1'b1;
          end
          r.off_timer_start = !shadow_cfg.emergency_hold && !e.occupied;
        end
      end
      if (shadow_cfg.area_mode) begin
        if (grouped) begin
          r.level_valid = 1'b1;
          r.level = LEVEL_FULL;
          if (shadow_cfg.output_path) stored_level = lvl;
        end
      end else begin
        r.level_valid = 1'b1;
        r.level = gated;
        stored_level = gated;
      end
      if (triac) begin
        r.switch_valid = 1'b1;
        r.switch_on = e.occupied && lvl != LEVEL_OFF;
      end
    end else if (active && e.opcode == OP_LIGHT && shadow_cfg.occupancy_gating &&
                 e.occupied) begin
      if (triac) begin
        r.switch_valid = 1'b1;
        r.switch_on = (lvl != LEVEL_OFF);
      end
      if (!shadow_cfg.area_mode) begin
        r.level_valid = 1'b1;
        r.level = lvl;
        stored_level = lvl;
        if (!shadow_cfg.output_path && integrated) begin
          r.switch_valid = 1'b1;
          r.switch_on = (lvl != LEVEL_OFF);
        end
      end
    end
    return r;
  endfunction

  function automatic script_row_t wr(input ddlc_cfg_idx_e idx, input logic [LUX_W-1:0] val);
    script_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic script_row_t ev(input logic op, input logic occ,
                                     input logic [LUX_W-1:0] lux, input logic ovr,
                                     input logic req, input bit known = 1'b0,
                                     input ddlc_res_t lit = NO_ACTION);
    script_row_t row;
    row = '0;
    row.evt = '{opcode: op, occupied: occ, lux: lux, override_flag: ovr, is_request: req};
    row.known = known;
    row.lit = lit;
    return row;
  endfunction

  task automatic write_reg(input ddlc_cfg_idx_e idx, input logic [LUX_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_TARGET_LUX:     shadow_cfg.target_lux = val;
      CFG_FULL_SCALE_LUX: shadow_cfg.full_scale_lux = val;
      CFG_AREA_MODE:      shadow_cfg.area_mode = val[0];
      CFG_IN_AREA:        shadow_cfg.in_area = val[0];
      CFG_OUTPUT_PATH:    shadow_cfg.output_path = val[0];
      CFG_BOARD_KIND:     shadow_cfg.board_kind = val[BOARD_W-1:0];
      CFG_OCC_GATING:     shadow_cfg.occupancy_gating = val[0];
      CFG_EMERG_HOLD:     shadow_cfg.emergency_hold = val[0];
      default: ;
    endcase
  endtask

  task automatic offer_event(input sensor_evt_t e, input bit known, input ddlc_res_t lit);
    ddlc_res_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    evt_if.valid <= 1'b1;
    evt_if.opcode <= e.opcode;
    evt_if.occupied <= e.occupied;
    evt_if.lux <= e.lux;
    evt_if.override <= e.override_flag;
    evt_if.is_request <= e.is_request;
    do @(posedge clk_i); while (!evt_if.ready);
    predicted = control_outcome(e);
    awaited_commands.push_back(known ? lit : predicted);
  endtask

  // The sender holds off until every outstanding result transaction has come back.
  task automatic drain_results();
    evt_if.valid <= 1'b0;
    while (awaited_commands.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (rst_ni && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    res_if.ready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin : result_check
    ddlc_res_t seen;
    ddlc_res_t due;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = ddlc_res_t'{res_if.level_valid, res_if.level, res_if.switch_valid,
                         res_if.switch_on, res_if.off_timer_start};
      if (awaited_commands.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: unexpected result: lv=%0b level=%0d sv=%0b on=%0b timer=%0b",
                   $realtime, seen.level_valid, seen.level, seen.switch_valid,
                   seen.switch_on, seen.off_timer_start);
        end
      end else begin
        due = awaited_commands.pop_front();
        if (seen.level_valid !== due.level_valid || seen.level !== due.level ||
            seen.switch_valid !== due.switch_valid || seen.switch_on !== due.switch_on ||
            seen.off_timer_start !== due.off_timer_start) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: mismatch: expected lv=%0b level=%0d sv=%0b on=%0b timer=%0b",
                     $realtime, due.level_valid, due.level, due.switch_valid,
                     due.switch_on, due.off_timer_start);
            $display("%0t:           actual lv=%0b level=%0d sv=%0b on=%0b timer=%0b",
                     $realtime, seen.level_valid, seen.level, seen.switch_valid,
                     seen.switch_on, seen.off_timer_start);
          end
        end
      end
    end
  end

  initial begin
    #1_500_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    script_row_t      script[$];
    sensor_evt_t      e;
    logic [LUX_W-1:0] target;
    logic [LUX_W-1:0] scale;
    int               span;
    int               near;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    evt_if.valid = 1'b0;
    evt_if.opcode = OP_OCCUPANCY;
    evt_if.occupied = 1'b0;
    evt_if.lux = '0;
    evt_if.override = 1'b0;
    evt_if.is_request = 1'b0;
    res_if.ready = 1'b0;

    shadow_cfg = '0;
    shadow_cfg.full_scale_lux = FULL_SCALE_RESET;
    shadow_cfg.board_kind = BOARD_INTEGRATED;
    shadow_cfg.occupancy_gating = 1'b1;
    stored_level = LEVEL_OFF;

    script = '{
      ev(OP_OCCUPANCY, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1,
         ddlc_res_t'{1'b1, LEVEL_OFF, 1'b0, 1'b0, 1'b0}),
      ev(OP_OCCUPANCY, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1,
         ddlc_res_t'{1'b1, LEVEL_OFF, 1'b0, 1'b0, 1'b1}),
      ev(OP_LIGHT, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1,
         ddlc_res_t'{1'b1, LEVEL_OFF, 1'b1, 1'b0, 1'b0}),
      ev(OP_LIGHT, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1, NO_ACTION),
      ev(OP_OCCUPANCY, 1'b1, 16'd0, 1'b0, 1'b1, 1'b1, NO_ACTION),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b1, 1'b0, 1'b1, NO_ACTION),
      wr(CFG_TARGET_LUX, 16'hFFFF),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1,
         ddlc_res_t'{1'b1, LEVEL_FULL, 1'b1, 1'b1, 1'b0}),
      ev(OP_OCCUPANCY, 1'b1, 16'hFFFF, 1'b0, 1'b0),
      wr(CFG_FULL_SCALE_LUX, 16'd0),
      ev(OP_LIGHT, 1'b1, 16'hFFFE, 1'b0, 1'b0),
      wr(CFG_FULL_SCALE_LUX, 16'd600),
      wr(CFG_TARGET_LUX, 16'd300),
      ev(OP_LIGHT, 1'b1, 16'd480, 1'b0, 1'b0),
      ev(OP_LIGHT, 1'b1, 16'd600, 1'b0, 1'b0),
      ev(OP_LIGHT, 1'b1, 16'd366, 1'b0, 1'b0),
      wr(CFG_BOARD_KIND, LUX_W'(BOARD_TRIAC)),
      ev(OP_OCCUPANCY, 1'b1, 16'd0, 1'b0, 1'b0),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b0, 1'b0),
      wr(CFG_AREA_MODE, 16'd1),
      wr(CFG_IN_AREA, 16'd1),
      ev(OP_OCCUPANCY, 1'b1, 16'd300, 1'b0, 1'b0),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b0, 1'b0),
      wr(CFG_OUTPUT_PATH, 16'd1),
      ev(OP_OCCUPANCY, 1'b1, 16'd600, 1'b0, 1'b0),
      ev(OP_OCCUPANCY, 1'b0, 16'd0, 1'b0, 1'b0),
      wr(CFG_BOARD_KIND, LUX_W'(BOARD_SPARE)),
      wr(CFG_AREA_MODE, 16'd0),
      ev(OP_OCCUPANCY, 1'b0, 16'd0, 1'b0, 1'b0),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b0, 1'b0),
      wr(CFG_OCC_GATING, 16'd0),
      ev(OP_LIGHT, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1, NO_ACTION),
      wr(CFG_EMERG_HOLD, 16'd1),
      wr(CFG_BOARD_KIND, LUX_W'(BOARD_INTEGRATED)),
      wr(CFG_OUTPUT_PATH, 16'd0),
      ev(OP_OCCUPANCY, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1,
         ddlc_res_t'{1'b1, LEVEL_OFF, 1'b0, 1'b0, 1'b0}),
      ev(OP_OCCUPANCY, 1'b1, 16'd0, 1'b1, 1'b1, 1'b1, NO_ACTION)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        drain_results();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        cfg_we <= 1'b0;
        offer_event(script[i].evt, script[i].known, script[i].lit);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      drain_results();
      if (p == Phases - 1) calm <= 1'b1;
      target = LUX_W'($urandom_range(0, 65535));
      scale = LUX_W'($urandom_range(50, 3000));
      case (p)
        1: begin
          target = 16'hFFFF;
          scale = 16'd0;
        end
        2: begin
          target = 16'd0;
          scale = 16'hFFFF;
        end
        3: scale = 16'd1;
        default: ;
      endcase
      write_reg(CFG_TARGET_LUX, target);
      write_reg(CFG_FULL_SCALE_LUX, scale);
      write_reg(CFG_AREA_MODE, LUX_W'($urandom_range(0, 1)));
      write_reg(CFG_IN_AREA, LUX_W'($urandom_range(0, 1)));
      write_reg(CFG_OUTPUT_PATH, LUX_W'($urandom_range(0, 1)));
      write_reg(CFG_BOARD_KIND, LUX_W'($urandom_range(0, 3)));
      write_reg(CFG_OCC_GATING, LUX_W'($urandom_range(0, 4) != 0));
      write_reg(CFG_EMERG_HOLD, LUX_W'($urandom_range(0, 1)));
      cfg_we <= 1'b0;

      repeat (RandomItems / Phases) begin
        e.opcode = $urandom_range(0, 1) ? OP_LIGHT : OP_OCCUPANCY;
        e.occupied = ($urandom_range(0, 3) != 0);
        e.override_flag = ($urandom_range(0, 9) == 0);
        e.is_request = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0) begin
          e.lux = LUX_W'($urandom_range(0, 65535));
        end else begin
          // Readings close to the setpoint keep the stored level moving both ways.
          span = ((shadow_cfg.full_scale_lux == '0) ? 1 : int'(shadow_cfg.full_scale_lux))
                 / 3 + 1;
          near = int'(shadow_cfg.target_lux) + int'($urandom_range(0, 2 * span)) - span;
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          e.lux = LUX_W'(near);
        end
        offer_event(e, 1'b0, NO_ACTION);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/ddlc_pkg.sv
src/ddlc_intf.sv
src/ddlc_serial_div.sv
src/ddlc_level_map.sv
src/daylight_dimming_level_control.sv
bench/daylight_dimming_level_control_tb.sv
